### rtl/usdt_pkg.sv
// Shared types and constants of the UDP socket demultiplexer table.
// Used by the channel interfaces and by the front end, engine and top level.
package usdt_pkg;

   localparam int MaxSocketsDefault = 16;
   localparam int HandleCount       = 16;
   localparam int HandleWidth       = 4;
   localparam int IpWidth           = 32;
   localparam int PortWidth         = 16;
   localparam int LenWidth          = 16;

   localparam logic [15:0] FirstFreePort = 16'd1024;
   localparam logic [15:0] HeaderBytes   = 16'd8;

   localparam logic [1:0] ACT_RECEIVE    = 2'd0;
   localparam logic [1:0] ACT_CONNECT    = 2'd1;
   localparam logic [1:0] ACT_LISTEN     = 2'd2;
   localparam logic [1:0] ACT_DISCONNECT = 2'd3;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NO_MATCH  = 3'd1;
   localparam logic [2:0] STATUS_SHORT     = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_NO_HANDLE = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] frame_length;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [15:0] listen_port;
      logic [3:0]  handle;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  result_handle;
      logic [15:0] assigned_port;
      logic [15:0] payload_length;
      logic        became_connected;
   } rsp_type;

   // Request as held in the queue, with its classification.
   typedef struct packed {
      req_type req;
      logic    short_frame;
   } item_type;

   typedef struct packed {
      logic        listening;
      logic [15:0] own_port;
      logic [31:0] own_ip;
      logic [15:0] far_port;
      logic [31:0] far_ip;
      logic [3:0]  handle;
   } entry_type;

endpackage

### rtl/usdt_if.sv
// Valid/ready channel interfaces of the socket table.
// Depends on usdt_pkg for the payload types.
interface usdt_req_if;
   logic             valid;
   logic             ready;
   usdt_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface usdt_rsp_if;
   logic             valid;
   logic             ready;
   usdt_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface usdt_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/usdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module usdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/usdt_front.sv
// Front end: accepts requests, flags short frames and queues them for the engine.
// Depends on usdt_pkg and usdt_if.
module usdt_front (
   input  logic                clock,
   input  logic                reset,
   usdt_req_if.sink            req_bus,
   output logic                q_valid,
   output usdt_pkg::item_type  q_item,
   input  logic                q_pop
);
   usdt_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;
   usdt_pkg::item_type new_item;

   assign req_bus.ready = (fill_ff != 2'd2);
   assign push = req_bus.valid && req_bus.ready;
   assign pop  = q_pop && (fill_ff != 2'd0);

   always_comb begin
      new_item.req         = req_bus.data;
      new_item.short_frame = (req_bus.data.action == usdt_pkg::ACT_RECEIVE) &&
                             (req_bus.data.frame_length < usdt_pkg::HeaderBytes);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_valid = (fill_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];
endmodule

### rtl/usdt_engine.sv
// Back end: scans and updates the packed socket table held in RAM.
// Depends on usdt_pkg, usdt_if and usdt_ram.
module usdt_engine #(
   parameter int MAX_SOCKETS = usdt_pkg::MaxSocketsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         host_ip,
   input  logic                q_valid,
   input  usdt_pkg::item_type  q_item,
   output logic                q_pop,
   usdt_rsp_if.source          rsp_bus,
   output logic [$clog2(MAX_SOCKETS+1)-1:0] entry_count,
   output logic [usdt_pkg::HandleCount-1:0] handle_map
);
   localparam int IW = (MAX_SOCKETS > 1) ? $clog2(MAX_SOCKETS) : 1;
   localparam int CW = $clog2(MAX_SOCKETS + 1);
   localparam int EW = $bits(usdt_pkg::entry_type);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_READ    = 6'b000010,
      S_CHECK   = 6'b000100,
      S_MOVE_RD = 6'b001000,
      S_MOVE_WR = 6'b010000,
      S_RESULT  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   usdt_pkg::req_type  item_ff, item_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [15:0]        hiu_ff, hiu_in;
   logic [15:0]        port_ff, port_in;
   usdt_pkg::rsp_type  res_ff, res_in;
   logic               out_valid_ff, out_valid_in;
   usdt_pkg::rsp_type  out_data_ff, out_data_in;

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   usdt_pkg::entry_type wr_entry;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic [EW-1:0]      rd_raw;
   usdt_pkg::entry_type rd_entry;

   logic [CW-1:0]      last;
   logic               at_last;
   logic [3:0]         free_handle;
   logic               local_hit;
   logic               remote_hit;

   usdt_ram #(.WIDTH(EW), .DEPTH(MAX_SOCKETS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry   = usdt_pkg::entry_type'(rd_raw);
   assign last       = count_ff - CW'(1);
   assign at_last    = (CW'(idx_ff) == last);
   assign local_hit  = (rd_entry.own_port == item_ff.dport) &&
                       (rd_entry.own_ip == item_ff.dst_ip);
   assign remote_hit = (rd_entry.far_port == item_ff.sport) &&
                       (rd_entry.far_ip == item_ff.src_ip);

   always_comb begin
      free_handle = '0;
      for (int h = usdt_pkg::HandleCount - 1; h >= 0; h--) begin
         if (!hiu_ff[h]) begin
            free_handle = 4'(h);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      hiu_in       = hiu_ff;
      port_in      = port_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_data_in  = out_data_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_entry     = rd_entry;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item.req;
               idx_in   = '0;
               res_in   = '0;
               state_in = S_RESULT;
               unique case (q_item.req.action)
                  usdt_pkg::ACT_RECEIVE: begin
                     if (q_item.short_frame) begin
                        res_in.status = usdt_pkg::STATUS_SHORT;
                     end else if (count_ff == '0) begin
                        res_in.status = usdt_pkg::STATUS_NO_MATCH;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  usdt_pkg::ACT_CONNECT, usdt_pkg::ACT_LISTEN: begin
                     if (count_ff == CW'(MAX_SOCKETS) || (&hiu_ff)) begin
                        res_in.status = usdt_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IW-1:0];
                        wr_entry.own_ip = host_ip;
                        wr_entry.handle = free_handle;
                        if (q_item.req.action == usdt_pkg::ACT_CONNECT) begin
                           wr_entry.listening   = 1'b0;
                           wr_entry.own_port    = port_ff;
                           wr_entry.far_port    = q_item.req.peer_port;
                           wr_entry.far_ip      = q_item.req.peer_ip;
                           res_in.assigned_port = port_ff;
                           port_in              = port_ff + 16'd1;
                        end else begin
                           wr_entry.listening   = 1'b1;
                           wr_entry.own_port    = q_item.req.listen_port;
                           wr_entry.far_port    = '0;
                           wr_entry.far_ip      = '0;
                           res_in.assigned_port = q_item.req.listen_port;
                        end
                        hiu_in[free_handle]  = 1'b1;
                        count_in             = count_ff + CW'(1);
                        res_in.status        = usdt_pkg::STATUS_OK;
                        res_in.result_handle = free_handle;
                     end
                  end
                  default: begin
                     if (!hiu_ff[q_item.req.handle] || count_ff == '0) begin
                        res_in.status = usdt_pkg::STATUS_NO_HANDLE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (item_ff.action == usdt_pkg::ACT_RECEIVE &&
                         local_hit && (rd_entry.listening || remote_hit)) begin
               // A listening entry latches the peer and turns connected
               res_in.status         = usdt_pkg::STATUS_OK;
               res_in.result_handle  = rd_entry.handle;
               res_in.payload_length = item_ff.frame_length - usdt_pkg::HeaderBytes;
               res_in.became_connected = rd_entry.listening;
               if (rd_entry.listening) begin
                  wr_en              = 1'b1;
                  wr_entry.listening = 1'b0;
                  wr_entry.far_port  = item_ff.sport;
                  wr_entry.far_ip    = item_ff.src_ip;
               end
               state_in = S_RESULT;
            end else if (item_ff.action == usdt_pkg::ACT_DISCONNECT &&
                         rd_entry.handle == item_ff.handle) begin
               res_in.status        = usdt_pkg::STATUS_OK;
               res_in.result_handle = item_ff.handle;
               state_in             = S_MOVE_RD;
            end else if (at_last) begin
               res_in.status = (item_ff.action == usdt_pkg::ACT_RECEIVE) ?
                               usdt_pkg::STATUS_NO_MATCH : usdt_pkg::STATUS_NO_HANDLE;
               state_in      = S_RESULT;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_READ;
            end
         end
         S_MOVE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = last[IW-1:0];
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            // Move the last entry into the freed slot
            wr_en                  = 1'b1;
            count_in               = last;
            hiu_in[item_ff.handle] = 1'b0;
            state_in               = S_RESULT;
         end
         S_RESULT: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in = 1'b1;
               out_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         hiu_ff       <= '0;
         port_ff      <= usdt_pkg::FirstFreePort;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hiu_ff       <= hiu_in;
         port_ff      <= port_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      idx_ff      <= idx_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_data_ff;
   assign entry_count   = count_ff;
   assign handle_map    = hiu_ff;
endmodule

### rtl/udp_socket_demux_table.sv
// Top level of the UDP socket demultiplexer table.
// Depends on usdt_pkg, usdt_if, usdt_front, usdt_engine and usdt_ram.
//
// Keeps a packed table of up to MAX_SOCKETS sockets and answers every request
// with exactly one response. Connect, listen, short frames and requests that
// fail without a table read go from the queue slot to the result register and
// on to the response register. Receive and disconnect walk the table through
// the single read port of the entry RAM, reading each entry visited and then
// checking it; a disconnect then reads the last entry and moves it into the
// freed slot. A two-deep queue takes requests while the engine works; the
// response register holds a result until it is taken. The user must write the
// host address through the csr channel only while idle; this is not enforced.
module udp_socket_demux_table #(
   parameter int MAX_SOCKETS = usdt_pkg::MaxSocketsDefault
) (
   input  logic      clock,
   input  logic      reset,
   usdt_req_if.sink  req_bus,
   usdt_rsp_if.source rsp_bus,
   usdt_csr_if.sink  csr_bus
);
   logic [31:0]               host_ip_ff;
   logic                      q_valid;
   usdt_pkg::item_type        q_item;
   logic                      q_pop;
   logic [$clog2(MAX_SOCKETS+1)-1:0] entry_count;
   logic [usdt_pkg::HandleCount-1:0] handle_map;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         host_ip_ff <= '0;
      end else if (csr_bus.valid) begin
         host_ip_ff <= csr_bus.data;
      end
   end

   usdt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   usdt_engine #(.MAX_SOCKETS(MAX_SOCKETS)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .host_ip     (host_ip_ff),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_bus     (rsp_bus),
      .entry_count (entry_count),
      .handle_map  (handle_map)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count <= ($clog2(MAX_SOCKETS+1))'(MAX_SOCKETS))
      else $error("entry count beyond table size");

   a_handles_track: assert property (@(posedge clock) disable iff (reset)
      $countones(handle_map) == int'(entry_count))
      else $error("handle map out of step with entry count");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.status != usdt_pkg::STATUS_OK |->
      rsp_bus.data.result_handle == '0 && rsp_bus.data.payload_length == '0)
      else $error("failed response carries data");
endmodule
